// ===== src/bcba_pkg.sv =====
// ----------------------------------------------------------------------------
// bcba_pkg
// Shared constants, codes and types for the bitmap contiguous block allocator.
// ----------------------------------------------------------------------------
package bcba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_W     = 8;
    localparam int MAP_DEPTH  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W     = $clog2(MAP_DEPTH);
    localparam int WORD_SHIFT = $clog2(WORD_W);
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = BLK_W + 1;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

    // running first-fit search state, carried from word to word
    typedef struct packed {
        logic [CNT_W-1:0] run;
        logic [BLK_W-1:0] first;
        logic             found;
        logic [BLK_W-1:0] hit;
    } scan_t;

endpackage

// ===== src/bcba_ram.sv =====
// ----------------------------------------------------------------------------
// bcba_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bcba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bcba_word_unit.sv =====
// ----------------------------------------------------------------------------
// bcba_word_unit
// Per-word datapath: advances the first-fit run search over one map word
// and builds the bit mask of a block range that falls in that word.
// ----------------------------------------------------------------------------
module bcba_word_unit (
    input  logic [bcba_pkg::WORD_W-1:0] word,
    input  logic [bcba_pkg::ADDR_W-1:0] word_addr,
    input  logic [bcba_pkg::CNT_W-1:0]  lim,
    input  logic [bcba_pkg::CNT_W-1:0]  cnt,
    input  bcba_pkg::scan_t             scan_in,
    input  logic [bcba_pkg::BLK_W-1:0]  lo,
    input  logic [bcba_pkg::BLK_W-1:0]  hi,
    output bcba_pkg::scan_t             scan_out,
    output logic [bcba_pkg::WORD_W-1:0] mask
);

    import bcba_pkg::*;

    always_comb
    begin
        scan_t            s;
        logic [BLK_W-1:0] b;
        logic             free;
        s       = scan_in;
        s.found = 1'b0;
        s.hit   = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            b    = {word_addr, i[WORD_SHIFT-1:0]};
            // blocks past the limit count as used so they never join a run
            free = !word[i] && ({1'b0, b} < lim);
            if (!s.found)
            begin
                if (!free)
                begin
                    s.run = '0;
                end
                else
                begin
                    if (s.run == '0)
                    begin
                        s.first = b;
                    end
                    s.run = s.run + 1'b1;
                    if (s.run == cnt)
                    begin
                        s.found = 1'b1;
                        s.hit   = b;
                    end
                end
            end
        end
        scan_out = s;
    end

    always_comb
    begin
        logic [BLK_W-1:0] b;
        for (int i = 0; i < WORD_W; i++)
        begin
            b       = {word_addr, i[WORD_SHIFT-1:0]};
            mask[i] = (b >= lo) && (b <= hi);
        end
    end

endmodule

// ===== src/bitmap_contiguous_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator
// First-fit contiguous block allocator over a one-bit-per-block used map
// held in a 512 x 8 RAM; allocate, release, reserve and query requests.
// ----------------------------------------------------------------------------
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+------------------------
//  request  | mode, block_number, count            | in_valid / in_ready
//  result   | status, start_block, used            | out_valid / out_ready
//  config   | cfg_wr_data (total_blocks)           | cfg_wr_en, no wait
//
//  One request at a time. Allocate scans one map word per cycle, then
//  marks the run at one word per cycle; release and reserve rewrite the
//  words spanned the same way. Cost is set by the RAM port.
//  After reset a clearing pass writes all 512 map words while in_ready
//  stays low. A pending result waits in the output register.
module bitmap_contiguous_block_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bcba_pkg::MODE_W-1:0]   mode,
    input  logic [bcba_pkg::BLK_W-1:0]    block_number,
    input  logic [bcba_pkg::CNT_W-1:0]    count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bcba_pkg::STATUS_W-1:0] status,
    output logic [bcba_pkg::BLK_W-1:0]    start_block,
    output logic                          used,
    input  logic                          cfg_wr_en,
    input  logic [bcba_pkg::CNT_W-1:0]    cfg_wr_data
);

    import bcba_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_RMW    = 3'd4;
    localparam logic [2:0] S_QUERY  = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W:0]     rd_cnt_reg, rd_cnt_next;
    logic [ADDR_W-1:0]   last_reg, last_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    total_blocks_reg, total_blocks_next;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [BLK_W-1:0]    blk_reg, blk_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [BLK_W-1:0]    lo_reg, lo_next;
    logic [BLK_W-1:0]    hi_reg, hi_next;
    logic                set_reg, set_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic [BLK_W-1:0]    first_reg, first_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [BLK_W-1:0]    res_start_reg, res_start_next;
    logic                res_used_reg, res_used_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BLK_W-1:0]    start_block_reg, start_block_next;
    logic                used_reg, used_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   new_word;
    logic [WORD_W-1:0]   mask;
    logic [CNT_W-1:0]    lim;
    logic [CNT_W-1:0]    lim_m1;
    logic [CNT_W:0]      range_end;
    logic [CNT_W:0]      range_last;
    logic                issue;
    scan_t               scan_in;
    scan_t               scan_out;

    assign lim        = (total_blocks_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                               : total_blocks_reg;
    assign lim_m1     = lim - 1'b1;
    assign range_end  = {2'b00, blk_reg} + {1'b0, cnt_reg};
    assign range_last = range_end - 1'b1;

    assign scan_in.run   = run_reg;
    assign scan_in.first = first_reg;
    assign scan_in.found = 1'b0;
    assign scan_in.hit   = '0;

    bcba_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAP_DEPTH)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_cnt_reg[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

    bcba_word_unit u_word (
        .word     (ram_rdata),
        .word_addr(pend_addr_reg),
        .lim      (lim),
        .cnt      (cnt_reg),
        .scan_in  (scan_in),
        .lo       (lo_reg),
        .hi       (hi_reg),
        .scan_out (scan_out),
        .mask     (mask)
    );

    assign new_word = set_reg ? (ram_rdata | mask) : (ram_rdata & ~mask);

    always_comb
    begin
        state_next        = state_reg;
        rd_cnt_next       = rd_cnt_reg;
        last_next         = last_reg;
        pend_next         = 1'b0;
        pend_addr_next    = pend_addr_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        total_blocks_next = cfg_wr_en ? cfg_wr_data : total_blocks_reg;
        mode_next         = mode_reg;
        blk_next          = blk_reg;
        cnt_next          = cnt_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        set_next          = set_reg;
        run_next          = run_reg;
        first_next        = first_reg;
        res_status_next   = res_status_reg;
        res_start_next    = res_start_reg;
        res_used_next     = res_used_reg;
        status_next       = status_reg;
        start_block_next  = start_block_reg;
        used_next         = used_reg;
        ram_we            = 1'b0;
        ram_waddr         = pend_addr_reg;
        ram_wdata         = new_word;
        issue             = 1'b0;

        // word reads stream one per cycle through the three RAM-walking states
        if (state_reg == S_SCAN || state_reg == S_RMW || state_reg == S_QUERY)
        begin
            issue = (rd_cnt_reg <= {1'b0, last_reg});
            if (issue)
            begin
                rd_cnt_next    = rd_cnt_reg + 1'b1;
                pend_next      = 1'b1;
                pend_addr_next = rd_cnt_reg[ADDR_W-1:0];
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = rd_cnt_reg[ADDR_W-1:0];
                ram_wdata   = '0;
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == (ADDR_W+1)'(MAP_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    blk_next   = block_number;
                    cnt_next   = count;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_status_next = ST_OK;
                res_start_next  = '0;
                res_used_next   = 1'b0;
                run_next        = '0;
                first_next      = '0;
                case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (cnt_reg == '0 || cnt_reg > lim)
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            rd_cnt_next = '0;
                            last_next   = lim_m1[BLK_W-1:WORD_SHIFT];
                            state_next  = S_SCAN;
                        end
                    end
                    MODE_RELEASE, MODE_RESERVE:
                    begin
                        if (cnt_reg == '0 || range_end > {1'b0, lim})
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            lo_next     = blk_reg;
                            hi_next     = range_last[BLK_W-1:0];
                            set_next    = (mode_reg == MODE_RESERVE);
                            rd_cnt_next = {1'b0, blk_reg[BLK_W-1:WORD_SHIFT]};
                            last_next   = range_last[BLK_W-1:WORD_SHIFT];
                            state_next  = S_RMW;
                        end
                    end
                    default:
                    begin
                        if ({1'b0, blk_reg} >= lim)
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            lo_next     = blk_reg;
                            rd_cnt_next = {1'b0, blk_reg[BLK_W-1:WORD_SHIFT]};
                            last_next   = blk_reg[BLK_W-1:WORD_SHIFT];
                            state_next  = S_QUERY;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                if (pend_reg)
                begin
                    if (scan_out.found)
                    begin
                        // switch to marking; drop the read already in flight
                        lo_next        = scan_out.first;
                        hi_next        = scan_out.hit;
                        set_next       = 1'b1;
                        res_start_next = scan_out.first;
                        rd_cnt_next    = {1'b0, scan_out.first[BLK_W-1:WORD_SHIFT]};
                        last_next      = scan_out.hit[BLK_W-1:WORD_SHIFT];
                        pend_next      = 1'b0;
                        state_next     = S_RMW;
                    end
                    else if (pend_addr_reg == last_reg)
                    begin
                        res_status_next = ST_NOSPACE;
                        pend_next       = 1'b0;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        run_next   = scan_out.run;
                        first_next = scan_out.first;
                    end
                end
            end
            S_RMW:
            begin
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                    if (pend_addr_reg == last_reg)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_RESULT;
                    end
                end
            end
            S_QUERY:
            begin
                if (pend_reg)
                begin
                    res_used_next = ram_rdata[lo_reg[WORD_SHIFT-1:0]];
                    pend_next     = 1'b0;
                    state_next    = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    status_next      = res_status_reg;
                    start_block_next = res_start_reg;
                    used_next        = res_used_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            rd_cnt_reg       <= '0;
            last_reg         <= '0;
            pend_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            total_blocks_reg <= CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            state_reg        <= state_next;
            rd_cnt_reg       <= rd_cnt_next;
            last_reg         <= last_next;
            pend_reg         <= pend_next;
            out_valid_reg    <= out_valid_next;
            total_blocks_reg <= total_blocks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg   <= pend_addr_next;
        mode_reg        <= mode_next;
        blk_reg         <= blk_next;
        cnt_reg         <= cnt_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        set_reg         <= set_next;
        run_reg         <= run_next;
        first_reg       <= first_next;
        res_status_reg  <= res_status_next;
        res_start_reg   <= res_start_next;
        res_used_reg    <= res_used_next;
        status_reg      <= status_next;
        start_block_reg <= start_block_next;
        used_reg        <= used_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign start_block = start_block_reg;
    assign used        = used_reg;

    // map writes only during the clearing pass or a read-modify-write pass
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_RMW))
        else $error("map write outside clear or rmw pass");

    // a write-back never lands past the last word of its range
    a_rmw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RMW && pend_reg) |-> (pend_addr_reg <= last_reg))
        else $error("rmw write beyond range");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (start_block == '0))
        else $error("nonzero start block on failed request");

    a_used_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && used) |-> (status == ST_OK))
        else $error("used flag on failed request");

    // a new result is loaded only once the previous transfer has gone out
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_valid_reg && !out_ready) |=> (state_reg == S_RESULT))
        else $error("result overwritten before transfer");

endmodule

// ===== sim/bcba_checker.sv =====
// ----------------------------------------------------------------------------
// bcba_checker
// Watches the request, result and config ports of the block allocator, keeps
// its own copy of the used map and the block limit, and predicts every result
// at request transfer. Each result transfer is checked against the oldest
// prediction. Mismatches and unexpected results are counted in fail_count.
// ----------------------------------------------------------------------------
module bcba_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [bcba_pkg::MODE_W-1:0]   mode,
    input  logic [bcba_pkg::BLK_W-1:0]    block_number,
    input  logic [bcba_pkg::CNT_W-1:0]    count,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [bcba_pkg::STATUS_W-1:0] status,
    input  logic [bcba_pkg::BLK_W-1:0]    start_block,
    input  logic                          used,
    input  logic                          cfg_wr_en,
    input  logic [bcba_pkg::CNT_W-1:0]    cfg_wr_data,
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bcba_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    start_block;
        logic                used;
    } alloc_result_t;

    bit   [MAX_BLOCKS-1:0] block_used;
    logic [CNT_W-1:0]      total_blocks;
    alloc_result_t         awaited_results[$];

    // Applies one request to the local map and returns what the block must answer.
    function automatic alloc_result_t serve_request(
        logic [MODE_W-1:0] req_mode,
        logic [BLK_W-1:0]  req_blk,
        logic [CNT_W-1:0]  req_cnt
    );
        alloc_result_t res;
        int            lim;
        int            run;
        int            first;
        int            b;
        bit            found;
        res   = '0;
        lim   = (int'(total_blocks) > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_blocks);
        run   = 0;
        first = 0;
        found = 1'b0;
        res.status = ST_OK;
        case (req_mode)
            MODE_ALLOC:
            begin
                if (req_cnt == '0 || int'(req_cnt) > lim)
                begin
                    res.status = ST_INVALID;
                end
                else
                begin
                    // first fit: lowest run of free blocks, all below the limit
                    for (b = 0; b < lim && !found; b++)
                    begin
                        if (block_used[b])
                        begin
                            run = 0;
                        end
                        else
                        begin
                            if (run == 0)
                                first = b;
                            run++;
                            if (run == int'(req_cnt))
                                found = 1'b1;
                        end
                    end
                    if (found)
                    begin
                        for (b = first; b < first + int'(req_cnt); b++)
                            block_used[b] = 1'b1;
                        res.start_block = BLK_W'(first);
                    end
                    else
                    begin
                        res.status = ST_NOSPACE;
                    end
                end
            end
            MODE_RELEASE, MODE_RESERVE:
            begin
                if (req_cnt == '0 || int'(req_blk) + int'(req_cnt) > lim)
                begin
                    res.status = ST_INVALID;
                end
                else
                begin
                    for (b = int'(req_blk); b < int'(req_blk) + int'(req_cnt); b++)
                        block_used[b] = (req_mode == MODE_RESERVE);
                end
            end
            MODE_QUERY:
            begin
                if (int'(req_blk) >= lim)
                    res.status = ST_INVALID;
                else
                    res.used = block_used[req_blk];
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            block_used   = '0;
            total_blocks = CNT_W'(MAX_BLOCKS);
            awaited_results.delete();
            pending      = 0;
            fail_count   = 0;
        end
        else
        begin
            if (cfg_wr_en)
                total_blocks = cfg_wr_data;

            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t ERROR: none expected, actual st=%0d start=%0d used=%0d",
                             $time, status, start_block, used);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status || start_block !== want.start_block ||
                        used !== want.used)
                    begin
                        $display("%0t ERROR: exp st=%0d start=%0d used=%0d, %s",
                                 $time, want.status, want.start_block, want.used,
                                 $sformatf("act st=%0d start=%0d used=%0d",
                                           status, start_block, used));
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready)
                awaited_results.push_back(serve_request(mode, block_number, count));

            pending = awaited_results.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bitmap contiguous block allocator: a directed pass over
// the field extremes and corner cases, then random request streams under a
// range of block limits and three sender/receiver idling profiles.
// Checking is done by bcba_checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcba_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [MODE_W-1:0]   mode;
    logic [BLK_W-1:0]    block_number;
    logic [CNT_W-1:0]    count;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    start_block;
    logic                used;
    logic                cfg_wr_en;
    logic [CNT_W-1:0]    cfg_wr_data;

    int                  fail_count;
    int                  pending;
    int unsigned         send_idle_pct;
    int unsigned         recv_idle_pct;
    int                  lim_now;

    // limit settings per idling profile; 8191 and 4097 clamp to the full map
    int phase_limits [3][4] = '{'{64, 1, 8191, 200},
                                '{37, 4096, 8, 300},
                                '{130, 4097, 16, 2}};
    int unsigned send_pct [3] = '{31, 83, 0};
    int unsigned recv_pct [3] = '{83, 31, 0};

    bitmap_contiguous_block_allocator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .block_number (block_number),
        .count        (count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .start_block  (start_block),
        .used         (used),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    bcba_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .block_number (block_number),
        .count        (count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .start_block  (start_block),
        .used         (used),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side stalls at random
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_request(logic [MODE_W-1:0] m, logic [BLK_W-1:0] b,
                                logic [CNT_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        block_number <= b;
        count        <= c;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(int v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(v);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        lim_now = (v > MAX_BLOCKS) ? MAX_BLOCKS : v;
    endtask

    // Mostly well-formed requests sized to the limit, with some raw noise.
    task automatic random_request();
        logic [MODE_W-1:0] m;
        int                pick;
        int                span;
        int                b;
        int                c;
        pick = $urandom_range(99);
        span = (lim_now >= 8) ? lim_now / 8 : 1;
        if (pick < 8)
        begin
            m = MODE_W'($urandom_range(3));
            b = $urandom_range(MAX_BLOCKS - 1);
            c = $urandom_range((1 << CNT_W) - 1);
        end
        else
        begin
            if (pick < 45)
                m = MODE_ALLOC;
            else if (pick < 70)
                m = MODE_RELEASE;
            else if (pick < 80)
                m = MODE_RESERVE;
            else
                m = MODE_QUERY;
            c = $urandom_range((m == MODE_RELEASE) ? 2 * span : span, 1);
            if (c > lim_now || $urandom_range(9) == 0)
                c = $urandom_range(lim_now, 1);
            b = $urandom_range(lim_now - c, 0);
            if (m == MODE_QUERY)
            begin
                b = $urandom_range(lim_now - 1, 0);
                c = $urandom_range((1 << CNT_W) - 1);
            end
        end
        push_request(m, BLK_W'(b), CNT_W'(c));
    endtask

    initial
    begin
        int p;
        int s;
        int n;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_ALLOC;
        block_number  = '0;
        count         = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        send_idle_pct = send_pct[0];
        recv_idle_pct = recv_pct[0];
        lim_now       = MAX_BLOCKS;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: full map at the reset limit
        push_request(MODE_ALLOC,   12'd0,    13'd0);
        push_request(MODE_ALLOC,   12'd0,    13'd4097);
        push_request(MODE_ALLOC,   12'd4095, 13'd8191);
        push_request(MODE_ALLOC,   12'd0,    13'd4096);
        push_request(MODE_ALLOC,   12'd0,    13'd1);
        push_request(MODE_QUERY,   12'd4095, 13'd8191);
        push_request(MODE_RELEASE, 12'd4095, 13'd2);
        push_request(MODE_RELEASE, 12'd0,    13'd0);
        push_request(MODE_RELEASE, 12'd0,    13'd4096);
        push_request(MODE_RESERVE, 12'd4090, 13'd6);
        push_request(MODE_RESERVE, 12'd4091, 13'd6);
        push_request(MODE_RESERVE, 12'd10,   13'd5);
        push_request(MODE_RESERVE, 12'd10,   13'd5);
        push_request(MODE_RELEASE, 12'd20,   13'd3);
        push_request(MODE_ALLOC,   12'd0,    13'd12);
        push_request(MODE_ALLOC,   12'd4095, 13'd10);
        push_request(MODE_QUERY,   12'd4095, 13'd0);
        push_request(MODE_QUERY,   12'd0,    13'd0);
        push_request(MODE_ALLOC,   12'd0,    13'd4070);

        // zero limit: everything is invalid
        write_limit(0);
        push_request(MODE_QUERY,   12'd0,    13'd1);
        push_request(MODE_ALLOC,   12'd0,    13'd1);
        push_request(MODE_RESERVE, 12'd0,    13'd1);

        // lowered limit keeps the upper bits, raised limit exposes them again
        write_limit(8);
        push_request(MODE_RELEASE, 12'd0,    13'd8);
        push_request(MODE_ALLOC,   12'd0,    13'd8);
        write_limit(8191);
        push_request(MODE_QUERY,   12'd4095, 13'd0);
        push_request(MODE_QUERY,   12'd8,    13'd0);

        for (p = 0; p < 3; p++)
        begin
            wait_drained();
            send_idle_pct = send_pct[p];
            recv_idle_pct = recv_pct[p];
            for (s = 0; s < 4; s++)
            begin
                write_limit(phase_limits[p][s]);
                // full-size maps are slow to scan, so fewer requests there
                for (n = 0; n < ((lim_now >= MAX_BLOCKS) ? 40 : 115); n++)
                    random_request();
            end
        end

        wait_drained();
        repeat (1100) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
